>>> rtl/avq_pkg.sv
package avq_pkg;

  // Opcode encodings on the request port
  localparam logic [2:0] OPC_INSERT = 3'd0;
  localparam logic [2:0] OPC_LOOKUP = 3'd1;
  localparam logic [2:0] OPC_TICK   = 3'd2;
  localparam logic [2:0] OPC_DELETE = 3'd3;
  localparam logic [2:0] OPC_MARK   = 3'd4;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_LOOKUP,
    OP_TICK,
    OP_DELETE,
    OP_MARK
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } cmd_t;

endpackage

>>> rtl/avq_front.sv
module avq_front #(
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2:0]           opcode_i,
  input  logic [ADDR_BITS-1:0] address_i,
  output logic                 busy_o,
  output avq_pkg::cmd_t        cmd_o,
  output logic [ADDR_BITS-1:0] address_o
);
  import avq_pkg::*;

  op_e                  op_class;
  op_e                  op_q [QDEPTH];
  logic [ADDR_BITS-1:0] addr_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]    count_q, count_d;
  logic                 full;
  logic                 push;
  logic                 pop;

  // Classify the request; unknown opcodes become a no-op
  always_comb begin
    case (opcode_i)
      OPC_INSERT: op_class = OP_INSERT;
      OPC_LOOKUP: op_class = OP_LOOKUP;
      OPC_TICK:   op_class = OP_TICK;
      OPC_DELETE: op_class = OP_DELETE;
      OPC_MARK:   op_class = OP_MARK;
      default:    op_class = OP_NOP;
    endcase
  end

  assign full   = (count_q == QCNT_W'(QDEPTH));
  assign busy_o = full;
  assign push   = start_i && !full;
  // The back end never stalls: drain one command every cycle while any is queued
  assign pop    = (count_q != '0);

  assign cmd_o.valid = pop;
  assign cmd_o.op    = op_q[rd_ptr_q];
  assign address_o   = addr_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]   <= op_class;
      addr_q[wr_ptr_q] <= address_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("command queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("command queue push lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("command queue pop lost");

endmodule

>>> rtl/avq_back.sv
module avq_back #(
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  avq_pkg::cmd_t        cmd_i,
  input  logic [ADDR_BITS-1:0] address_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic                 mark_o
);
  import avq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int AGE_W = $clog2(DEPTH);

  logic [DEPTH-1:0]     valid_q, valid_d;
  logic [ADDR_BITS-1:0] addr_q [DEPTH];
  logic [AGE_W-1:0]     age_q  [DEPTH];
  logic [AGE_W-1:0]     age_d  [DEPTH];
  logic [DEPTH-1:0]     mark_q, mark_d;

  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     expire;
  logic                 any_match;
  logic                 any_free;
  logic [IDX_W-1:0]     match_idx;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     exp_idx;
  logic [IDX_W-1:0]     slot;
  logic                 do_insert;
  logic                 do_age;

  logic                 done_q, hit_q, mark_res_q;
  logic                 hit_d, mark_res_d;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i]  = valid_q[i] && (addr_q[i] == address_i);
      expire[i] = valid_q[i] && (age_q[i] == AGE_W'(DEPTH - 1));
    end
  end

  // Lowest match and lowest free entry
  always_comb begin
    any_match = 1'b0;
    any_free  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_match = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Highest expiring entry, entry 0 when none expires
  always_comb begin
    exp_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (expire[i]) begin
        exp_idx = IDX_W'(i);
      end
    end
  end

  assign slot      = any_free ? free_idx : exp_idx;
  assign do_insert = cmd_i.valid && (cmd_i.op == OP_INSERT);
  assign do_age    = cmd_i.valid && ((cmd_i.op == OP_INSERT) || (cmd_i.op == OP_TICK));

  always_comb begin
    valid_d    = valid_q;
    mark_d     = mark_q;
    hit_d      = 1'b0;
    mark_res_d = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      age_d[i] = age_q[i];
    end
    if (do_age) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (valid_q[i]) begin
          age_d[i]   = age_q[i] + 1'b1;
          valid_d[i] = !expire[i];
        end
      end
    end
    if (do_insert) begin
      valid_d[slot] = 1'b1;
      age_d[slot]   = '0;
      mark_d[slot]  = 1'b0;
    end
    if (cmd_i.valid) begin
      case (cmd_i.op)
        OP_LOOKUP: begin
          hit_d      = any_match;
          mark_res_d = any_match && mark_q[match_idx];
        end
        OP_DELETE: begin
          if (any_match) valid_d[match_idx] = 1'b0;
        end
        OP_MARK: begin
          if (any_match) mark_d[match_idx] = 1'b1;
        end
        default: begin
          hit_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_q     <= mark_d;
    hit_q      <= hit_d;
    mark_res_q <= mark_res_d;
    for (int i = 0; i < DEPTH; i++) begin
      age_q[i] <= age_d[i];
    end
    if (do_insert) begin
      addr_q[slot] <= address_i;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q && done_q;
  assign mark_o = mark_res_q && done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_i.valid))
    else $error("result without a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_o |-> hit_o)
    else $error("mark reported without hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> valid_q[$past(slot)])
    else $error("inserted entry not valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && (cmd_i.op == OP_DELETE) && any_match) |=> !valid_q[$past(match_idx)])
    else $error("deleted entry still valid");

endmodule

>>> rtl/aging_victim_address_queue.sv
// Aging victim address queue: a fully associative store of DEPTH line
// addresses with per-entry age and mark. A request is accepted at a clock
// edge where start_i is high and busy_o is low, and a new one can be taken
// every cycle. The back end executes one queued request per cycle and
// compares all entries in parallel, so the two-entry command queue never
// holds more than one request and busy_o never rises. Every request,
// including a no-op opcode, yields exactly one result. The request passes
// through the command queue and then the result register; done_o rises as
// the result is registered, and each result is shown for a single cycle
// with hit_o and mark_o valid in it. The receiver cannot stall, so results
// must be sampled on the done_o cycle. After reset all entries are empty;
// no clearing pass is needed.
module aging_victim_address_queue #(
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2:0]           opcode_i,
  input  logic [ADDR_BITS-1:0] address_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic                 hit_o,
  output logic                 mark_o
);
  import avq_pkg::*;

  cmd_t                 cmd;
  logic [ADDR_BITS-1:0] cmd_addr;

  avq_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .opcode_i  (opcode_i),
    .address_i (address_i),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .address_o (cmd_addr)
  );

  avq_back #(
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .address_i (cmd_addr),
    .done_o    (done_o),
    .hit_o     (hit_o),
    .mark_o    (mark_o)
  );

endmodule

>>> tb/aging_victim_address_queue_tb.sv
`timescale 1ns / 100ps

module aging_victim_address_queue_tb;
  import avq_pkg::*;

  localparam int DEPTH = 16;
  localparam int ADDR_BITS = 48;
  localparam int AGE_W = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1800;
  localparam int BURST_LEN = 40;
  localparam int POOL_N = 12;
  localparam int MAX_GAP = 10;
  localparam int CYCLE_LIMIT = 200000;

  // opcodes the block leaves undefined
  localparam logic [2:0] OPC_RSVD_LO = 3'd5;
  localparam logic [2:0] OPC_RSVD_HI = 3'd7;

  localparam logic [ADDR_BITS-1:0] ADDR_ZERO = '0;
  localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;
  localparam logic [ADDR_BITS-1:0] ADDR_CHECKER = 48'hA5A5_5A5A_0F0F;

  typedef struct packed {
    logic hit;
    logic mark;
  } hit_mark_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [ADDR_BITS-1:0] addr;
    logic                 typed;
    logic                 hit;
    logic                 mark;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic [2:0]           opcode_i = OPC_LOOKUP;
  logic [ADDR_BITS-1:0] address_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic                 hit_o;
  logic                 mark_o;

  // travel with the request so the checker knows when a row has a typed answer
  logic req_typed = 1'b0;
  logic req_hit = 1'b0;
  logic req_mark = 1'b0;

  // predicted victim store
  logic             slot_valid [DEPTH];
  logic [ADDR_BITS-1:0] slot_addr [DEPTH];
  logic [AGE_W-1:0] slot_age [DEPTH];
  logic             slot_mark [DEPTH];

  hit_mark_t hit_mark_q[$];
  logic [ADDR_BITS-1:0] addr_pool [POOL_N];

  int errors = 0;
  int cycle_count = 0;
  int op_seen [8];
  int hits_seen = 0;
  int marked_hits = 0;
  int expirations = 0;

  aging_victim_address_queue #(
    .DEPTH(DEPTH),
    .ADDR_BITS(ADDR_BITS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .opcode_i(opcode_i),
    .address_i(address_i),
    .busy_o(busy_o),
    .done_o(done_o),
    .hit_o(hit_o),
    .mark_o(mark_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_BITS-1:0] random_address();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ADDR_BITS-1:0];
  endfunction

  // Advance the predicted store by one request and return hit/mark.
  function automatic hit_mark_t victim_store_step(logic [2:0] op,
                                                  logic [ADDR_BITS-1:0] addr);
    hit_mark_t res;
    int match_slot;
    int free_slot;
    int gone_slot;
    res = '0;
    match_slot = -1;
    for (int i = DEPTH - 1; i >= 0; i--)
      if (slot_valid[i] && slot_addr[i] == addr) match_slot = i;
    case (op)
      OPC_INSERT: begin
        free_slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--)
          if (!slot_valid[i]) free_slot = i;
        gone_slot = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[i]) begin
            slot_age[i] = slot_age[i] + 1'b1;
            if (slot_age[i] == DEPTH) begin
              slot_valid[i] = 1'b0;
              gone_slot = i;
              expirations++;
            end
          end
        end
        // full store: reuse the slot that just expired, else slot 0
        if (free_slot < 0) free_slot = gone_slot;
        slot_valid[free_slot] = 1'b1;
        slot_addr[free_slot] = addr;
        slot_age[free_slot] = '0;
        slot_mark[free_slot] = 1'b0;
      end
      OPC_LOOKUP: begin
        if (match_slot >= 0) begin
          res.hit = 1'b1;
          res.mark = slot_mark[match_slot];
        end
      end
      OPC_TICK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[i]) begin
            if (slot_age[i] < DEPTH) slot_age[i] = slot_age[i] + 1'b1;
            if (slot_age[i] >= DEPTH) begin
              slot_valid[i] = 1'b0;
              expirations++;
            end
          end
        end
      end
      OPC_DELETE: begin
        if (match_slot >= 0) slot_valid[match_slot] = 1'b0;
      end
      OPC_MARK: begin
        if (match_slot >= 0) slot_mark[match_slot] = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Predict on each accepted request, then check any result in the same edge.
  always @(posedge clk_i) begin
    hit_mark_t predicted;
    hit_mark_t want;
    if (rst_ni && start_i && !busy_o) begin
      predicted = victim_store_step(opcode_i, address_i);
      if (req_typed) begin
        predicted.hit = req_hit;
        predicted.mark = req_mark;
      end
      hit_mark_q.push_back(predicted);
      op_seen[opcode_i]++;
    end
    if (rst_ni && done_o) begin
      if (hit_mark_q.size() == 0) begin
        $display("%0t: result with nothing pending: hit %b mark %b", $time, hit_o, mark_o);
        errors++;
      end else begin
        want = hit_mark_q.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch: expected %b, actual %b", $time, want.hit, hit_o);
          errors++;
        end
        if (mark_o !== want.mark) begin
          $display("%0t: mark mismatch: expected %b, actual %b", $time, want.mark, mark_o);
          errors++;
        end
        if (hit_o === 1'b1) hits_seen++;
        if (hit_o === 1'b1 && mark_o === 1'b1) marked_hits++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending",
               $time, cycle_count, hit_mark_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request after an idle gap and hold it until accepted.
  task automatic issue(input logic [2:0] op, input logic [ADDR_BITS-1:0] addr,
                       input logic typed, input logic hit, input logic mark,
                       input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    opcode_i  <= op;
    address_i <= addr;
    req_typed <= typed;
    req_hit   <= hit;
    req_mark  <= mark;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    stim_row_t plan [24];
    int mode;
    int pick;
    int slot;
    int gap;
    logic [2:0] op;
    logic [ADDR_BITS-1:0] addr;

    for (int i = 0; i < DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_addr[i] = '0;
      slot_age[i] = '0;
      slot_mark[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    for (int i = 0; i < POOL_N; i++) addr_pool[i] = random_address();

    plan = '{
      '{OPC_LOOKUP,  ADDR_ZERO,    1'b1, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ONES,    1'b1, 1'b0, 1'b0},
      '{OPC_INSERT,  ADDR_ONES,    1'b1, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ONES,    1'b1, 1'b1, 1'b0},
      '{OPC_MARK,    ADDR_ONES,    1'b1, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ONES,    1'b1, 1'b1, 1'b1},
      '{OPC_INSERT,  ADDR_ZERO,    1'b1, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ZERO,    1'b1, 1'b1, 1'b0},
      '{OPC_DELETE,  ADDR_ZERO,    1'b1, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ZERO,    1'b1, 1'b0, 1'b0},
      '{OPC_DELETE,  ADDR_ZERO,    1'b1, 1'b0, 1'b0},
      '{OPC_MARK,    ADDR_ZERO,    1'b1, 1'b0, 1'b0},
      '{OPC_TICK,    ADDR_ONES,    1'b1, 1'b0, 1'b0},
      '{OPC_RSVD_LO, ADDR_ONES,    1'b1, 1'b0, 1'b0},
      '{OPC_RSVD_HI, ADDR_ZERO,    1'b1, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ONES,    1'b1, 1'b1, 1'b1},
      '{OPC_INSERT,  ADDR_ONES,    1'b0, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ONES,    1'b0, 1'b0, 1'b0},
      '{OPC_DELETE,  ADDR_ONES,    1'b0, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_ONES,    1'b0, 1'b0, 1'b0},
      '{OPC_INSERT,  ADDR_CHECKER, 1'b0, 1'b0, 1'b0},
      '{OPC_MARK,    ADDR_CHECKER, 1'b0, 1'b0, 1'b0},
      '{OPC_LOOKUP,  ADDR_CHECKER, 1'b0, 1'b0, 1'b0},
      '{OPC_RSVD_HI, ADDR_CHECKER, 1'b0, 1'b0, 1'b0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i])
      issue(plan[i].op, plan[i].addr, plan[i].typed, plan[i].hit, plan[i].mark,
            $urandom_range(0, MAX_GAP));

    // Mostly reuse a small address pool so lookups, deletes and marks hit;
    // insert-heavy bursts fill the store and drive entries to expiry.
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BURST_LEN == 0) mode = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < (mode == 1 ? 70 : 30)) begin
        op = OPC_INSERT;
      end else begin
        pick = $urandom_range(0, 7);
        case (pick)
          0, 1, 2, 3: op = OPC_LOOKUP;
          4:          op = OPC_TICK;
          5:          op = OPC_DELETE;
          6:          op = OPC_MARK;
          default:    op = 3'($urandom_range(OPC_RSVD_LO, OPC_RSVD_HI));
        endcase
      end
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, POOL_N - 1);
      if (pick < 80) begin
        if (op == OPC_INSERT && $urandom_range(0, 3) == 0)
          addr_pool[slot] = random_address();
        addr = addr_pool[slot];
      end else if (pick < 84) begin
        addr = ($urandom_range(0, 1) != 0) ? ADDR_ONES : ADDR_ZERO;
      end else begin
        addr = random_address();
      end
      gap = $urandom_range(0, MAX_GAP);
      issue(op, addr, 1'b0, 1'b0, 1'b0, gap);
    end
    start_i <= 1'b0;

    while (hit_mark_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Requests: %0d insert, %0d lookup, %0d tick, %0d delete, %0d mark, %0d undefined",
             op_seen[OPC_INSERT], op_seen[OPC_LOOKUP], op_seen[OPC_TICK],
             op_seen[OPC_DELETE], op_seen[OPC_MARK],
             op_seen[5] + op_seen[6] + op_seen[7]);
    $display("Lookup hits %0d (%0d marked), entries aged out %0d, mismatches %0d",
             hits_seen, marked_hits, expirations, errors);
    if (errors == 0 && hit_mark_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
